>>> design/adler32_pkg.sv
// adler32_pkg: shared constants, widths and the item record for the adler32 checksum block
// used by adler32_lane_sum, adler32_accum and adler32_checksum; depends on nothing
package adler32_pkg;

	localparam int BYTES_PER_ITEM = 8;
	localparam int DATA_W         = 64;
	localparam int COUNT_W        = 4;
	localparam int SUM_W          = 16;
	localparam int ADLER_MOD      = 65521;
	localparam int FOLD_MUL       = 65536 - ADLER_MOD;

	localparam int CNT_W      = $clog2(BYTES_PER_ITEM + 1);
	localparam int LANE_W     = 8 * BYTES_PER_ITEM;
	localparam int EXT_W      = (LANE_W > DATA_W) ? LANE_W : DATA_W;
	localparam int BSUM_MAX   = 255 * BYTES_PER_ITEM;
	localparam int WSUM_MAX   = 255 * BYTES_PER_ITEM * (BYTES_PER_ITEM + 1) / 2;
	localparam int BSUM_W     = $clog2(BSUM_MAX + 1);
	localparam int WSUM_W     = $clog2(WSUM_MAX + 1);
	localparam int LOW_ACC_W  = $clog2(ADLER_MOD - 1 + BSUM_MAX + 1);
	localparam int HIGH_ACC_W = $clog2((ADLER_MOD - 1) * (BYTES_PER_ITEM + 1) + WSUM_MAX + 1);
	localparam int FOLD_W     = SUM_W + 1;

	typedef struct packed {
		logic [BSUM_W-1:0] byte_sum;
		logic [WSUM_W-1:0] weight_sum;
		logic [CNT_W-1:0]  count;
		logic              first;
		logic              last;
	} adler32_item_t;

endpackage

>>> design/adler32_lane_sum.sv
// adler32_lane_sum: input register and per-item byte sum and weighted byte sum
// depends on adler32_pkg
module adler32_lane_sum
	import adler32_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [DATA_W-1:0]   data_bytes,
	input  logic [COUNT_W-1:0]  byte_count,
	input  logic                first,
	input  logic                last,
	output logic                item_valid,
	input  logic                item_take,
	output adler32_item_t       item_s2
);

	logic              v_s1;
	logic              v_s2;
	logic [LANE_W-1:0] data_s1;
	logic [CNT_W-1:0]  count_s1;
	logic              first_s1;
	logic              last_s1;
	logic              s2_free;
	logic              accept;
	logic [EXT_W-1:0]  data_ext;
	logic [CNT_W-1:0]  cnt_sat;
	logic [BSUM_W-1:0] bsum;
	logic [WSUM_W-1:0] wsum;
	logic [CNT_W-1:0]  weight;

	assign s2_free  = !v_s2 || item_take;
	assign in_stall = v_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;
	assign data_ext = EXT_W'(data_bytes);
	assign cnt_sat  = (int'(byte_count) > BYTES_PER_ITEM) ? CNT_W'(BYTES_PER_ITEM)
	                                                      : CNT_W'(byte_count);

	// byte sum and sum of bytes weighted by how many high-sum adds include them
	always_comb begin
		bsum   = '0;
		wsum   = '0;
		weight = '0;
		for (int i = 0; i < BYTES_PER_ITEM; i++) begin
			if (i < int'(count_s1)) begin
				weight = count_s1 - CNT_W'(i);
				bsum   = bsum + BSUM_W'(data_s1[8*i +: 8]);
				wsum   = wsum + WSUM_W'(weight) * WSUM_W'(data_s1[8*i +: 8]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && !s2_free);
			v_s2 <= (v_s1 && s2_free) || (v_s2 && !item_take);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= data_ext[LANE_W-1:0];
			count_s1 <= cnt_sat;
			first_s1 <= first;
			last_s1  <= last;
		end
		if (s2_free) begin
			item_s2.byte_sum   <= bsum;
			item_s2.weight_sum <= wsum;
			item_s2.count      <= count_s1;
			item_s2.first      <= first_s1;
			item_s2.last       <= last_s1;
		end
	end

	assign item_valid = v_s2;

endmodule

>>> design/adler32_accum.sv
// adler32_accum: running low and high sums with modular reduction, and the result register
// depends on adler32_pkg
module adler32_accum
	import adler32_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_take,
	input  adler32_item_t   item_s2,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [31:0]     checksum
);

	logic [SUM_W-1:0]      low_q;
	logic [SUM_W-1:0]      high_q;
	logic                  out_valid_q;
	logic [31:0]           checksum_q;
	logic                  out_free;
	logic [SUM_W-1:0]      base_lo;
	logic [SUM_W-1:0]      base_hi;
	logic [LOW_ACC_W-1:0]  lo_raw;
	logic [LOW_ACC_W-1:0]  lo_red;
	logic [SUM_W-1:0]      lo_new;
	logic [HIGH_ACC_W-1:0] hi_raw;
	logic [FOLD_W-1:0]     hi_fold;
	logic [FOLD_W-1:0]     hi_red;
	logic [SUM_W-1:0]      hi_new;

	assign out_free  = !out_valid_q || !out_stall;
	assign item_take = item_valid && (!item_s2.last || out_free);

	assign base_lo = item_s2.first ? SUM_W'(1) : low_q;
	assign base_hi = item_s2.first ? SUM_W'(0) : high_q;

	// low sum
	assign lo_raw = LOW_ACC_W'(base_lo) + LOW_ACC_W'(item_s2.byte_sum);
	assign lo_red = (lo_raw >= LOW_ACC_W'(ADLER_MOD)) ? lo_raw - LOW_ACC_W'(ADLER_MOD) : lo_raw;
	assign lo_new = lo_red[SUM_W-1:0];

	// high sum: old high + count * old low + weighted bytes, then fold 2^16 into 15
	assign hi_raw  = HIGH_ACC_W'(base_hi)
	               + HIGH_ACC_W'(base_lo) * HIGH_ACC_W'(item_s2.count)
	               + HIGH_ACC_W'(item_s2.weight_sum);
	assign hi_fold = FOLD_W'(hi_raw[SUM_W-1:0])
	               + FOLD_W'(hi_raw[HIGH_ACC_W-1:SUM_W]) * FOLD_W'(FOLD_MUL);
	assign hi_red  = (hi_fold >= FOLD_W'(ADLER_MOD)) ? hi_fold - FOLD_W'(ADLER_MOD) : hi_fold;
	assign hi_new  = hi_red[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= SUM_W'(1);
			high_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_take) begin
				low_q  <= lo_new;
				high_q <= hi_new;
			end
			if (out_free) begin
				out_valid_q <= item_take && item_s2.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && item_take && item_s2.last) begin
			checksum_q <= {hi_new, lo_new};
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;

endmodule

>>> design/adler32_checksum.sv
// adler32_checksum: top level of the Adler-32 checksum engine
// depends on adler32_pkg, adler32_lane_sum and adler32_accum
//
// usage
//   input channel: in_valid / in_stall with data_bytes, byte_count, first, last.
//   each transfer carries up to eight bytes, byte 0 in bits 7..0 taken first;
//   byte_count above eight counts as eight. first restarts the sums (low 1,
//   high 0) before the bytes; last makes one result after the bytes.
//   output channel: out_valid / out_stall with checksum, high sum in 31..16,
//   low sum in 15..0. items without last give no output transfer.
//   throughput: one input transfer every cycle while the output is not stalled;
//   the running sums update from a precomputed byte sum and weighted sum.
//   output path: the last item goes through the input register, then the
//   lane-sum register, then the result register, where checksum becomes valid.
//   reset: arst_n clears the pipeline and output valid and sets low 1, high 0.
//   a stalled output holds checksum; the pipeline keeps taking items until the
//   lane-sum stage holds a last item that cannot move and the input register
//   is occupied, then in_stall rises.
module adler32_checksum
	import adler32_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [DATA_W-1:0]  data_bytes,
	input  logic [COUNT_W-1:0] byte_count,
	input  logic               first,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        checksum
);

	adler32_item_t item_s2;
	logic          item_valid;
	logic          item_take;

	adler32_lane_sum u_lane_sum (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_bytes (data_bytes),
		.byte_count (byte_count),
		.first      (first),
		.last       (last),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item_s2    (item_s2)
	);

	adler32_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item_s2    (item_s2),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.checksum   (checksum)
	);

endmodule

>>> design/adler32_checker.sv
// adler32_port_props: port-level assertions for adler32_checksum and the bind that attaches them
// depends on adler32_checksum's ports only
module adler32_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] checksum
);

	logic [2:0] pend_q;
	logic       in_last_xfer;
	logic       out_xfer;

	assign in_last_xfer = in_valid && !in_stall && last;
	assign out_xfer     = out_valid && !out_stall;

	// last items taken in whose checksum has not been transferred out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(in_last_xfer) - 3'(out_xfer);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(checksum))
		else $error("stalled checksum changed or dropped");

	a_out_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("checksum without a pending last item");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("more pending last items than pipeline stages");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'd0 && in_last_xfer |=> !out_valid)
		else $error("checksum appeared too early");

endmodule

bind adler32_checksum adler32_port_props u_adler32_port_props (.*);
